### design/sleep_timer_table_defines.svh
// Assertion macros used by the checker file of the sleep timer table.
`ifndef SLEEP_TIMER_TABLE_DEFINES_SVH
`define SLEEP_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define STT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sleep_timer_table check failed");

// Next-cycle implication, sampled on clk, quiet during rst.
`define STT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sleep_timer_table check failed");

`endif

### design/stt_pkg.sv
package stt_pkg;

  // Table depth and derived widths
  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int TID_W  = 8;
  localparam int DUR_W  = 32;

  // Input action codes
  localparam logic ACT_SLEEP = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_WOKEN    = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_IGNORED  = 2'd2,
    KIND_FULL     = 2'd3
  } kind_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic sleep;       // sleep request this cycle
    logic tick_start;  // load scan counters
    logic scan;        // process the head entry
    logic flush;       // emit held wake result, commit count
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_zero;    // table empty
    logic scan_last;   // this scan step handles the final entry
  } sts_t;

endpackage

### design/stt_ctrl.sv
module stt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          action,
  input  stt_pkg::sts_t sts,
  output stt_pkg::cmd_t cmd,
  output logic          busy
);

  stt_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      stt_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (action == stt_pkg::ACT_SLEEP) begin
            cmd.sleep = 1'b1;
          end else if (!sts.cnt_zero) begin
            cmd.tick_start = 1'b1;
            state_next     = stt_pkg::ST_SCAN;
          end
        end
      end
      stt_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = stt_pkg::ST_FLUSH;
        end
      end
      stt_pkg::ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = stt_pkg::ST_IDLE;
      end
      default: begin
        state_next = stt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### design/stt_datapath.sv
module stt_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  stt_pkg::cmd_t              cmd,
  input  logic [stt_pkg::TID_W-1:0]  thread_id,
  input  logic [stt_pkg::DUR_W-1:0]  duration,
  output stt_pkg::sts_t              sts,
  output logic                       strobe,
  output logic [1:0]                 kind,
  output logic [stt_pkg::TID_W-1:0]  woken_thread,
  output logic                       last
);

  // Table storage, newest entry at slot 0; valid slots are 0..count-1
  logic [stt_pkg::TID_W-1:0] slot_thread         [stt_pkg::SLOTS];
  logic [stt_pkg::DUR_W-1:0] slot_remaining      [stt_pkg::SLOTS];
  logic [stt_pkg::TID_W-1:0] slot_thread_next    [stt_pkg::SLOTS];
  logic [stt_pkg::DUR_W-1:0] slot_remaining_next [stt_pkg::SLOTS];

  logic [stt_pkg::CNT_W-1:0] count;
  logic [stt_pkg::CNT_W-1:0] tot;   // entries still in table during a scan
  logic [stt_pkg::CNT_W-1:0] step;  // entries left to scan
  logic                      pend_valid;
  logic [stt_pkg::TID_W-1:0] pend_thread;
  stt_pkg::kind_t            kind_q;

  logic                       is_full;
  logic                       ins;
  logic [stt_pkg::DUR_W-1:0]  rem_dec;
  logic                       wake;
  logic                       keep;
  logic [stt_pkg::SLOT_W-1:0] wr_idx;

  // Head-of-table decode and insert decision
  assign is_full = (count == stt_pkg::CNT_W'(stt_pkg::SLOTS));
  assign ins     = cmd.sleep && (duration != '0) && !is_full;
  assign rem_dec = slot_remaining[0] - stt_pkg::DUR_W'(1);
  assign wake    = (rem_dec == '0);
  assign keep    = cmd.scan && !wake;
  assign wr_idx  = stt_pkg::SLOT_W'(tot - stt_pkg::CNT_W'(1));

  assign sts.cnt_zero  = (count == '0);
  assign sts.scan_last = (step == stt_pkg::CNT_W'(1));

  // Table moves: shift down on insert; on a scan step drop a woken head, or rotate a kept head to the tail
  always_comb begin
    for (int i = 0; i < stt_pkg::SLOTS; i++) begin
      slot_thread_next[i]    = slot_thread[i];
      slot_remaining_next[i] = slot_remaining[i];
      if (ins) begin
        if (i == 0) begin
          slot_thread_next[i]    = thread_id;
          slot_remaining_next[i] = duration;
        end else begin
          slot_thread_next[i]    = slot_thread[i-1];
          slot_remaining_next[i] = slot_remaining[i-1];
        end
      end else if (cmd.scan) begin
        if (keep && (wr_idx == stt_pkg::SLOT_W'(i))) begin
          slot_thread_next[i]    = slot_thread[0];
          slot_remaining_next[i] = rem_dec;
        end else if (i < stt_pkg::SLOTS - 1) begin
          slot_thread_next[i]    = slot_thread[i+1];
          slot_remaining_next[i] = slot_remaining[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < stt_pkg::SLOTS; i++) begin
      slot_thread[i]    <= slot_thread_next[i];
      slot_remaining[i] <= slot_remaining_next[i];
    end
  end

  // Counters, held wake result and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      tot        <= '0;
      step       <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      // a beat goes out for every sleep and for every released wake
      strobe <= cmd.sleep || (cmd.scan && wake && pend_valid) || (cmd.flush && pend_valid);
      if (cmd.sleep) begin
        woken_thread <= thread_id;
        last         <= 1'b1;
        if (duration == '0) begin
          kind_q <= stt_pkg::KIND_IGNORED;
        end else if (is_full) begin
          kind_q <= stt_pkg::KIND_FULL;
        end else begin
          kind_q <= stt_pkg::KIND_ACCEPTED;
          count  <= count + stt_pkg::CNT_W'(1);
        end
      end
      if (cmd.tick_start) begin
        tot        <= count;
        step       <= count;
        pend_valid <= 1'b0;
      end
      // A woken entry is held until the next wake or the flush so the final one can carry last
      if (cmd.scan) begin
        step <= step - stt_pkg::CNT_W'(1);
        if (wake) begin
          tot         <= tot - stt_pkg::CNT_W'(1);
          pend_valid  <= 1'b1;
          pend_thread <= slot_thread[0];
          if (pend_valid) begin
            kind_q       <= stt_pkg::KIND_WOKEN;
            woken_thread <= pend_thread;
            last         <= 1'b0;
          end
        end
      end
      if (cmd.flush) begin
        count      <= tot;
        pend_valid <= 1'b0;
        if (pend_valid) begin
          kind_q       <= stt_pkg::KIND_WOKEN;
          woken_thread <= pend_thread;
          last         <= 1'b1;
        end
      end
    end
  end

  assign kind = kind_q;

endmodule

### design/sleep_timer_table.sv
// Sleep timer table: holds up to 16 sleeping threads, newest first. An item
// is taken when start is high and busy is low. A sleep item (action 0) is
// answered by exactly one status beat on the cycle after it is taken (kind
// accepted, ignored for a zero duration, or table full), and busy stays low,
// so a new item may follow every cycle. A tick item (action 1) walks the
// table one entry per cycle through a single decrement-and-compare unit: busy
// stays high through the scan and flush states (it stays low with an empty
// table), and each woken thread id comes out newest first as a kind-0 beat,
// the last one marked by last. A woken id is held back until the walk finds
// the next woken entry or ends, and the final woken beat appears on the first
// cycle busy is low again; a tick that wakes nothing produces no beat at all.
// Result beats last one cycle on strobe and cannot be held off, so the
// receiver must take every beat.
module sleep_timer_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      action,
  input  logic [stt_pkg::TID_W-1:0] thread_id,
  input  logic [stt_pkg::DUR_W-1:0] duration,
  output logic                      strobe,
  output logic [1:0]                kind,
  output logic [stt_pkg::TID_W-1:0] woken_thread,
  output logic                      last
);

  stt_pkg::cmd_t cmd;
  stt_pkg::sts_t sts;

  // Sequencer
  stt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Table and result path
  stt_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .thread_id    (thread_id),
    .duration     (duration),
    .sts          (sts),
    .strobe       (strobe),
    .kind         (kind),
    .woken_thread (woken_thread),
    .last         (last)
  );

endmodule

### design/sleep_timer_table_sva.sv
`include "sleep_timer_table_defines.svh"

module sleep_timer_table_sva (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      action,
  input logic [stt_pkg::TID_W-1:0] thread_id,
  input logic [stt_pkg::DUR_W-1:0] duration,
  input logic                      strobe,
  input logic [1:0]                kind,
  input logic [stt_pkg::TID_W-1:0] woken_thread,
  input logic                      last
);

  // Status beats are always final
  `STT_ASSERT_NOW(a_status_last, strobe && (kind != stt_pkg::KIND_WOKEN), last)

  // A taken sleep item answers next cycle with a status echoing its id
  `STT_ASSERT_NEXT(a_sleep_answer, start && !busy && (action == stt_pkg::ACT_SLEEP), strobe && (kind != stt_pkg::KIND_WOKEN) && (woken_thread == $past(thread_id)))

  // Zero duration is reported as ignored
  `STT_ASSERT_NEXT(a_zero_ignored, start && !busy && (action == stt_pkg::ACT_SLEEP) && (duration == '0), kind == stt_pkg::KIND_IGNORED)

  // More wake beats pending keeps the block busy
  `STT_ASSERT_NOW(a_wake_busy, strobe && (kind == stt_pkg::KIND_WOKEN) && !last, busy)

  // Final wake beat coincides with the return to idle
  `STT_ASSERT_NOW(a_wake_done, strobe && (kind == stt_pkg::KIND_WOKEN) && last, !busy)

endmodule

bind sleep_timer_table sleep_timer_table_sva u_sva (.*);

### test/tb.sv
module tb;
  import stt_pkg::*;

  localparam int IDLE_LIMIT   = 2000;         // cycles with no beat in or out
  localparam int TAIL_CYCLES  = 3 * SLOTS + 8; // longest tick walk plus slack
  localparam int RANDOM_ITEMS = 145;

  // One result beat as seen on the output ports
  typedef struct packed {
    kind_t            kind;
    logic [TID_W-1:0] tid;
    logic             last;
  } beat_t;

  // One stimulus row; pinned rows carry a hand-written result
  typedef struct packed {
    logic             act;
    logic [TID_W-1:0] tid;
    logic [DUR_W-1:0] dur;
    logic             pinned;
    beat_t            pin;
  } row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             action = ACT_SLEEP;
  logic [TID_W-1:0] thread_id = '0;
  logic [DUR_W-1:0] duration = '0;
  logic             pin_on = 1'b0;
  beat_t            pin_beat = '0;
  logic             busy;
  logic             strobe;
  logic [1:0]       kind;
  logic [TID_W-1:0] woken_thread;
  logic             last;

  // Shadow copy of the sleep table
  logic             shadow_used [SLOTS];
  logic [TID_W-1:0] shadow_tid [SLOTS];
  logic [DUR_W-1:0] shadow_left [SLOTS];

  beat_t due_beats [$];   // results still to come, oldest first
  beat_t fresh [$];       // results of the item just taken
  row_t  plan [$];        // directed rows

  int errors = 0;
  int idle_cycles = 0;
  int n_beats = 0;
  int n_sleeps = 0;
  int n_ticks = 0;
  int n_woken = 0;
  int n_full = 0;
  int n_ignored = 0;

  sleep_timer_table uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .thread_id    (thread_id),
    .duration     (duration),
    .strobe       (strobe),
    .kind         (kind),
    .woken_thread (woken_thread),
    .last         (last)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    $display("MISMATCH at beat %0d: %s", n_beats, msg);
    errors++;
  endtask

  // Apply one item to the shadow table and collect the results it causes
  function automatic void sleep_table_step(input logic act, input logic [TID_W-1:0] tid,
                                           input logic [DUR_W-1:0] dur);
    int keep;
    beat_t b;
    fresh.delete();
    if (act == ACT_SLEEP) begin
      if (dur == '0) begin
        fresh.push_back('{KIND_IGNORED, tid, 1'b1});
      end else if (shadow_used[SLOTS-1]) begin
        fresh.push_back('{KIND_FULL, tid, 1'b1});
      end else begin
        // newest entry goes to the front
        for (int i = SLOTS - 1; i > 0; i--) begin
          shadow_used[i] = shadow_used[i-1];
          shadow_tid[i]  = shadow_tid[i-1];
          shadow_left[i] = shadow_left[i-1];
        end
        shadow_used[0] = 1'b1;
        shadow_tid[0]  = tid;
        shadow_left[0] = dur;
        fresh.push_back('{KIND_ACCEPTED, tid, 1'b1});
      end
    end else begin
      // decrement all, wake the ones at zero, compact survivors in order
      keep = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (shadow_used[i]) begin
          shadow_left[i] = shadow_left[i] - 1'b1;
          if (shadow_left[i] == '0) begin
            fresh.push_back('{KIND_WOKEN, shadow_tid[i], 1'b0});
          end else begin
            shadow_tid[keep]  = shadow_tid[i];
            shadow_left[keep] = shadow_left[i];
            keep++;
          end
        end
      end
      for (int i = 0; i < SLOTS; i++) shadow_used[i] = (i < keep);
      if (fresh.size() > 0) begin
        b = fresh.pop_back();
        b.last = 1'b1;
        fresh.push_back(b);
      end
    end
  endfunction

  // Check result beats, predict on taken items, watch for a hang
  always @(posedge clk) begin
    beat_t b;
    logic took;
    took = !rst && start && !busy;
    // empty shadow table while in reset
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) shadow_used[i] = 1'b0;
    end
    if (!rst && strobe) begin
      n_beats++;
      if (due_beats.size() == 0) begin
        report($sformatf("beat with nothing due: kind %0d thread %0h last %0b",
                         kind, woken_thread, last));
      end else begin
        b = due_beats.pop_front();
        if (kind !== b.kind)
          report($sformatf("kind %0d, want %0d", kind, b.kind));
        if (woken_thread !== b.tid)
          report($sformatf("thread %0h, want %0h", woken_thread, b.tid));
        if (last !== b.last)
          report($sformatf("last %0b, want %0b", last, b.last));
      end
    end
    if (took) begin
      sleep_table_step(action, thread_id, duration);
      if (pin_on) begin
        due_beats.push_back(pin_beat);
      end else begin
        foreach (fresh[i]) due_beats.push_back(fresh[i]);
      end
      if (action == ACT_TICK) begin
        n_ticks++;
        n_woken += fresh.size();
      end else begin
        n_sleeps++;
        if (fresh[0].kind == KIND_FULL) n_full++;
        if (fresh[0].kind == KIND_IGNORED) n_ignored++;
      end
    end
    // watchdog
    if (took || (!rst && strobe)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results still due",
               IDLE_LIMIT, due_beats.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void add_row(input logic act, input logic [TID_W-1:0] tid,
                                  input logic [DUR_W-1:0] dur, input logic pinned,
                                  input kind_t k);
    row_t r;
    r.act = act;
    r.tid = tid;
    r.dur = dur;
    r.pinned = pinned;
    r.pin = '{k, tid, 1'b1};
    plan.push_back(r);
  endfunction

  // Random item; fill phases lean to sleeps, drain phases to ticks
  function automatic row_t random_row(input bit filling);
    row_t r;
    int p;
    r = '0;
    r.tid = TID_W'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < (filling ? 20 : 55)) begin
      r.act = ACT_TICK;
      r.dur = $urandom;   // don't care on a tick
    end else begin
      r.act = ACT_SLEEP;
      p = $urandom_range(0, 99);
      if (p < 6) r.dur = '0;
      else if (p < 10) r.dur = $urandom;
      else if (p < 16) r.dur = DUR_W'($urandom_range(9, 40));
      else r.dur = DUR_W'($urandom_range(1, 8));
    end
    return r;
  endfunction

  // Present one beat and hold it until taken
  task automatic send(input row_t r);
    start     <= 1'b1;
    action    <= r.act;
    thread_id <= r.tid;
    duration  <= r.dur;
    pin_on    <= r.pinned;
    pin_beat  <= r.pin;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop sending until every due result has come out
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (due_beats.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int burst_left;
    bit filling;
    row_t r;

    // directed rows: empty tick, zero duration, extremes, duplicate id,
    // fill to the top, sleep into a full table, mass wakes, quiet tick
    add_row(ACT_TICK,  8'h00, 32'h0000_0000, 1'b0, KIND_WOKEN);
    add_row(ACT_SLEEP, 8'h00, 32'h0000_0000, 1'b1, KIND_IGNORED);
    add_row(ACT_SLEEP, 8'hFF, 32'hFFFF_FFFF, 1'b1, KIND_ACCEPTED);
    add_row(ACT_SLEEP, 8'hA5, 32'h0000_0001, 1'b1, KIND_ACCEPTED);
    add_row(ACT_SLEEP, 8'hA5, 32'h0000_0001, 1'b1, KIND_ACCEPTED);
    add_row(ACT_TICK,  8'h5A, 32'h0000_0000, 1'b0, KIND_WOKEN);
    for (int k = 0; k < SLOTS - 1; k++)
      add_row(ACT_SLEEP, TID_W'(8'h11 * k), DUR_W'(1 + k % 2), 1'b1, KIND_ACCEPTED);
    add_row(ACT_SLEEP, 8'h3C, 32'h0000_0005, 1'b1, KIND_FULL);
    add_row(ACT_TICK,  8'h00, 32'h0000_0000, 1'b0, KIND_WOKEN);
    add_row(ACT_TICK,  8'h00, 32'h0000_0000, 1'b0, KIND_WOKEN);
    add_row(ACT_TICK,  8'h00, 32'hFFFF_FFFF, 1'b0, KIND_WOKEN);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part, back to back
    foreach (plan[i]) send(plan[i]);
    drain();

    // random part in bursts with gaps
    sent = 0;
    filling = 1'b1;
    burst_left = $urandom_range(1, 12);
    while (sent < RANDOM_ITEMS) begin
      if (sent % 25 == 24) filling = !filling;
      r = random_row(filling);
      send(r);
      sent++;
      if (sent % 50 == 0) begin
        drain();
      end else begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          hold_off($urandom_range(1, 8));
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d sleeps (%0d ignored, %0d into a full table) and %0d ticks,",
             n_sleeps, n_ignored, n_full, n_ticks);
    $display("with %0d threads woken and %0d result beats checked", n_woken, n_beats);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/stt_pkg.sv
design/stt_ctrl.sv
design/stt_datapath.sv
design/sleep_timer_table.sv
design/sleep_timer_table_sva.sv
test/tb.sv
